// File: sv/nlt_pkg.sv
package nlt_pkg;

  localparam int unsigned TICK_W = 32;
  localparam int unsigned ADDR_W = 6;
  localparam int unsigned CNT_W  = 7;

  localparam logic [TICK_W-1:0] TIMEOUT_RESET = 32'd1000;

  // Operation codes carried by the operation field
  typedef enum logic {
    OP_HEARD = 1'b0,
    OP_SWEEP = 1'b1
  } op_e;

  // One table entry as it travels along the chain
  typedef struct packed {
    logic              valid;
    logic [TICK_W-1:0] tick;
  } nlt_entry_t;

  // Per-step report of the head unit to the sequencer
  typedef struct packed {
    logic live;
    logic added;
    logic evicted;
  } nlt_step_t;

endpackage

// File: sv/neighbor_liveness_table_unit.sv
// Channel   Direction  Handshake                     Payload
// in        input      in_valid_i / in_stall_o       operation_i, address_i, now_tick_i
// out       output     out_valid_o / out_stall_i     member_count_o, table_empty_o,
//                                                    lowest_member_o, evicted_count_o,
//                                                    newly_added_o
// cfg       input      psel/penable/pwrite/pready    paddr, pwdata, prdata
//
// A result is ready once its transaction has passed every entry: the table entries
// sit in a ring of cells that rotates one place per cycle, unless held, past a single update
// unit at its front. in_stall_o is high while a transaction is in the ring, so a new one is
// taken only after the previous pass ends, even while the previous result waits on a stalled output.
// A stalled output holds the ring at its last step until the result register frees.
// Reset clears all valid bits and the counters; no clearing pass is needed.
module neighbor_liveness_table_unit #(
  parameter int unsigned TABLE_SIZE = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         operation_i,
  input  logic [nlt_pkg::ADDR_W-1:0]   address_i,
  input  logic [nlt_pkg::TICK_W-1:0]   now_tick_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [nlt_pkg::CNT_W-1:0]    member_count_o,
  output logic                         table_empty_o,
  output logic [nlt_pkg::ADDR_W-1:0]   lowest_member_o,
  output logic [nlt_pkg::CNT_W-1:0]    evicted_count_o,
  output logic                         newly_added_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import nlt_pkg::*;

  localparam int unsigned IW = $clog2(TABLE_SIZE);
  localparam int unsigned NW = $clog2(TABLE_SIZE + 1);
  localparam int unsigned CW = (IW > ADDR_W) ? IW : ADDR_W;
  localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_SIZE - 1);

  // Configuration register
  logic [TICK_W-1:0] timeout_q;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : timeout_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TIMEOUT_RESET;
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      timeout_q <= pwdata;
    end
  end

  // Sequencer state
  logic              busy_q;
  logic [IW-1:0]     idx_q;
  logic              op_q;
  logic [ADDR_W-1:0] addr_q;
  logic [TICK_W-1:0] now_q;
  logic [NW-1:0]     live_q, live_d;
  logic [NW-1:0]     evict_q, evict_d;
  logic [IW-1:0]     lowest_q, lowest_d;
  logic              found_q, found_d;
  logic              added_q, added_d;

  logic              out_valid_q;
  logic [CNT_W-1:0]  member_count_q;
  logic              table_empty_q;
  logic [ADDR_W-1:0] lowest_member_q;
  logic [CNT_W-1:0]  evicted_count_q;
  logic              newly_added_q;

  logic in_take, last, out_take, hold, shift, hit;

  nlt_entry_t chain [TABLE_SIZE];
  nlt_entry_t head_in, head_out;
  nlt_step_t  step;

  assign in_stall_o = busy_q;
  assign in_take    = in_valid_i && !busy_q;
  assign out_take   = out_valid_q && !out_stall_i;
  assign last       = (idx_q == LAST_IDX);
  assign hold       = last && out_valid_q && out_stall_i;
  assign shift      = busy_q && !hold;
  assign hit        = (CW'(idx_q) == CW'(addr_q));

  // Ring of cells: each takes its right neighbor, the tail takes the head result
  assign head_in = chain[0];

  for (genvar i = 0; i < TABLE_SIZE; i++) begin : g_cell
    nlt_entry_t cell_in;
    if (i == TABLE_SIZE - 1) begin : g_tail
      assign cell_in = head_out;
    end else begin : g_mid
      assign cell_in = chain[i+1];
    end
    nlt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (shift),
      .entry_i (cell_in),
      .entry_o (chain[i])
    );
  end

  nlt_head u_head (
    .op_i      (op_q),
    .hit_i     (hit),
    .now_i     (now_q),
    .timeout_i (timeout_q),
    .entry_i   (head_in),
    .entry_o   (head_out),
    .step_o    (step)
  );

  // Accumulate this step's contribution
  always_comb begin
    live_d   = live_q + NW'(step.live);
    evict_d  = evict_q + NW'(step.evicted);
    added_d  = added_q | step.added;
    found_d  = found_q | step.live;
    lowest_d = lowest_q;
    if (step.live && !found_q) begin
      lowest_d = idx_q;
    end
  end

  // Advance the ring, latch the transaction, publish the result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      idx_q       <= '0;
      live_q      <= '0;
      evict_q     <= '0;
      lowest_q    <= '0;
      found_q     <= 1'b0;
      added_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_take) begin
        out_valid_q <= 1'b0;
      end
      if (in_take) begin
        busy_q   <= 1'b1;
        idx_q    <= '0;
        live_q   <= '0;
        evict_q  <= '0;
        lowest_q <= '0;
        found_q  <= 1'b0;
        added_q  <= 1'b0;
      end else if (shift) begin
        live_q   <= live_d;
        evict_q  <= evict_d;
        lowest_q <= lowest_d;
        found_q  <= found_d;
        added_q  <= added_d;
        if (last) begin
          busy_q      <= 1'b0;
          idx_q       <= '0;
          out_valid_q <= 1'b1;
        end else begin
          idx_q <= idx_q + 1'b1;
        end
      end
    end
  end

  // Transaction and result payload
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      op_q   <= operation_i;
      addr_q <= address_i;
      now_q  <= now_tick_i;
    end
    if (shift && last) begin
      member_count_q  <= CNT_W'(live_d);
      table_empty_q   <= (live_d == '0);
      lowest_member_q <= ADDR_W'(lowest_d);
      evicted_count_q <= CNT_W'(evict_d);
      newly_added_q   <= added_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign member_count_o  = member_count_q;
  assign table_empty_o   = table_empty_q;
  assign lowest_member_o = lowest_member_q;
  assign evicted_count_o = evicted_count_q;
  assign newly_added_o   = newly_added_q;

endmodule

// File: sv/nlt_cell.sv
module nlt_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               shift_i,
  input  nlt_pkg::nlt_entry_t entry_i,
  output nlt_pkg::nlt_entry_t entry_o
);
  import nlt_pkg::*;

  logic              valid_q;
  logic [TICK_W-1:0] tick_q;

  // Take the neighbor's entry on every shift
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (shift_i) begin
      valid_q <= entry_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      tick_q <= entry_i.tick;
    end
  end

  assign entry_o.valid = valid_q;
  assign entry_o.tick  = tick_q;

endmodule

// File: sv/nlt_head.sv
module nlt_head (
  input  logic                  op_i,
  input  logic                  hit_i,
  input  logic [nlt_pkg::TICK_W-1:0] now_i,
  input  logic [nlt_pkg::TICK_W-1:0] timeout_i,
  input  nlt_pkg::nlt_entry_t   entry_i,
  output nlt_pkg::nlt_entry_t   entry_o,
  output nlt_pkg::nlt_step_t    step_o
);
  import nlt_pkg::*;

  logic [TICK_W-1:0] deadline;
  logic              expired;

  // Wrapping deadline, compared unsigned against the current tick
  assign deadline = entry_i.tick + timeout_i;
  assign expired  = entry_i.valid && (deadline < now_i);

  // Update the entry leaving the front of the chain
  always_comb begin
    entry_o       = entry_i;
    step_o.added   = 1'b0;
    step_o.evicted = 1'b0;
    unique case (op_e'(op_i))
      OP_HEARD: begin
        if (hit_i) begin
          entry_o.valid = 1'b1;
          entry_o.tick  = now_i;
          step_o.added  = !entry_i.valid;
        end
      end
      OP_SWEEP: begin
        if (expired) begin
          entry_o.valid  = 1'b0;
          step_o.evicted = 1'b1;
        end
      end
      default: ;
    endcase
    step_o.live = entry_o.valid;
  end

endmodule
